// ----- rtl/sgs_pkg.sv -----
package sgs_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_KERNEL_RAD   = 3'd2,
    REG_COEF_INNER   = 3'd3,
    REG_COEF_OUTER   = 3'd4
  } sgs_reg_t;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int HVAL_W     = 16;   // 8.8 horizontal intermediate
  localparam int SMOOTH_W   = 15;
  localparam int ROW_W      = 11;
  localparam int CFG_W      = 64;
  localparam int DIM_W      = 11;
  localparam int RAD_W      = 3;
  localparam int HEIGHT_LIM = 1024;

  // Accumulator widths for at most fifteen taps.
  localparam int HDOT_W = 28;
  localparam int VDOT_W = 36;
  localparam int WSUM_W = 20;

  // Shared divider: quotient known to fit DIV_Q_W bits.
  localparam int DIV_Q_W   = 16;
  localparam int DIV_DEN_W = WSUM_W;
  localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [COEF_W-1:0] tap_weight(input logic [CFG_W-1:0] inner,
                                                   input logic [CFG_W-1:0] outer,
                                                   input logic [2:0]       k);
    logic [5:0] base;
    base = {k[1:0], 4'b0000};
    if (k[2]) begin
      return outer[base +: COEF_W];
    end
    return inner[base +: COEF_W];
  endfunction

endpackage

// ----- rtl/sgs_if.sv -----
interface sgs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [sgs_pkg::PIX_W-1:0]   pixel;

  modport source (output valid, output opcode, output pixel, input ready);
  modport sink   (input valid, input opcode, input pixel, output ready);
endinterface

interface sgs_out_if;
  logic                         valid;
  logic                         ready;
  logic [sgs_pkg::SMOOTH_W-1:0] smoothed;
  logic                         frame_end;
  logic                         run_last;

  modport source (output valid, output smoothed, output frame_end, output run_last,
                  input ready);
  modport sink   (input valid, input smoothed, input frame_end, input run_last,
                  output ready);
endinterface

// ----- rtl/sgs_cell.sv -----
module sgs_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift_en,
  input  logic [sgs_pkg::PIX_W-1:0] pix_in,
  output logic [sgs_pkg::PIX_W-1:0] pix_out
);

  logic [sgs_pkg::PIX_W-1:0] pix_r;

  // Take the neighbor's pixel on each shift.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else if (shift_en) begin
      pix_r <= pix_in;
    end
  end

  assign pix_out = pix_r;

endmodule

// ----- rtl/sgs_div.sv -----
module sgs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sgs_pkg::div_req_t req,
  output sgs_pkg::div_rsp_t rsp
);

  localparam int QW = sgs_pkg::DIV_Q_W;
  localparam int DW = sgs_pkg::DIV_DEN_W;
  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [QW-1:0] lo_r;
  logic [QW-1:0] quot_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, lo_r[QW-1]};
  assign fits  = trial >= {1'b0, den_r};

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r  <= req.num[DW+QW-1:QW];
        lo_r   <= req.num[QW-1:0];
        den_r  <= req.den;
        quot_r <= '0;
        cnt_r  <= CW'(QW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
        quot_r <= {quot_r[QW-2:0], fits};
        lo_r   <= {lo_r[QW-2:0], 1'b0};
        cnt_r  <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// ----- rtl/separable_gaussian_smoother_unit.sv -----
// Separable Gaussian smoother with border-renormalized taps. Pixels enter one word at a
// time in raster order on in_chan (opcode 0 = pixel, 1 = flush); results leave on
// out_chan as the blurred value times 90, rounded half up, lagging the input by R rows
// and R columns. After the last pixel send R*W flush words to drain the bottom rows.
// Program image_width, image_height and kernel_radius through cfg_* while the block is
// idle; each of these writes restarts the frame. Coefficients are Q0.16, offset 0 in
// the low bits of coef_inner_taps. A word that finishes no column, or a flush inside
// the picture, is taken with no further work. Every column a word finishes adds
// work: the horizontal pass walks 2R+1 taps through one multiply-accumulate, the
// vertical pass takes a line store read and an accumulate step per tap, and both
// passes share one 16-step divider. A column that yields a result may also wait on
// out_chan; a column in the first R rows yields none; the drain rows skip the
// horizontal pass. The last column of a row yields up to R+1 results. No clearing
// pass is run after reset. The output word register lets a new input word be taken
// while a result still waits on out_chan.
module separable_gaussian_smoother_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  sgs_in_if.sink                      in_chan,
  sgs_out_if.source                   out_chan,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [sgs_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int WIN_LEN   = 2 * MAX_RADIUS + 1;
  localparam int KW        = $clog2(WIN_LEN);
  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int EW        = $clog2(MAX_WIDTH + 1);
  localparam int CMPW      = (EW > sgs_pkg::DIM_W) ? EW : sgs_pkg::DIM_W;
  localparam int SW        = XW + 2;
  localparam int SLW       = $clog2(2 * MAX_RADIUS);
  localparam int STORE_LEN = 2 * MAX_RADIUS * MAX_WIDTH;
  localparam int AW        = $clog2(STORE_LEN);
  localparam int RW        = sgs_pkg::ROW_W;
  localparam int JW        = RW + 2;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_XBEG   = 13'b0000000000010,
    S_HACC   = 13'b0000000000100,
    S_HSTART = 13'b0000000001000,
    S_HDIV   = 13'b0000000010000,
    S_VBEG   = 13'b0000000100000,
    S_VRD    = 13'b0000001000000,
    S_VACC   = 13'b0000010000000,
    S_VNUM   = 13'b0000100000000,
    S_VSTART = 13'b0001000000000,
    S_VDIV   = 13'b0010000000000,
    S_OUT    = 13'b0100000000000,
    S_WR     = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [sgs_pkg::DIM_W-1:0] img_w_r, img_h_r;
  logic [sgs_pkg::RAD_W-1:0] rad_r;
  logic [sgs_pkg::CFG_W-1:0] coef_in_r, coef_out_r;

  // Raster position and item context.
  logic [XW-1:0]  col_r;
  logic [RW-1:0]  row_r;
  logic [SLW-1:0] slot_r;
  logic           drain_r;
  logic [XW-1:0]  x_r, hi_r;
  logic [3:0]     t_r;
  logic [SLW-1:0] vslot_r;

  // Datapath.
  logic [sgs_pkg::HDOT_W-1:0]    dot_r;
  logic [sgs_pkg::WSUM_W-1:0]    sum_r;
  logic [sgs_pkg::HVAL_W-1:0]    h_r;
  logic [sgs_pkg::VDOT_W-1:0]    vdot_r;
  logic [sgs_pkg::WSUM_W-1:0]    vsum_r;
  logic [sgs_pkg::DIV_NUM_W-1:0] vnum_r;
  logic [sgs_pkg::HVAL_W-1:0]    mem_q_r;
  logic [sgs_pkg::SMOOTH_W-1:0]  vres_r;

  // Output word register.
  logic                         out_valid_r;
  logic [sgs_pkg::SMOOTH_W-1:0] out_smooth_r;
  logic                         out_fe_r, out_last_r;

  logic [sgs_pkg::HVAL_W-1:0] store_mem [STORE_LEN];

  // Effective geometry.
  logic [EW-1:0]             w_eff;
  logic [RW-1:0]             h_eff;
  logic [sgs_pkg::RAD_W-1:0] r_eff;
  logic [3:0]                two_r;

  always_comb begin
    if (img_w_r == '0) begin
      w_eff = EW'(1);
    end else if (CMPW'(img_w_r) > CMPW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(img_w_r);
    end
    if (img_h_r == '0) begin
      h_eff = RW'(1);
    end else if (img_h_r > RW'(sgs_pkg::HEIGHT_LIM)) begin
      h_eff = RW'(sgs_pkg::HEIGHT_LIM);
    end else begin
      h_eff = img_h_r;
    end
    if (rad_r > sgs_pkg::RAD_W'(MAX_RADIUS)) begin
      r_eff = sgs_pkg::RAD_W'(MAX_RADIUS);
    end else begin
      r_eff = rad_r;
    end
  end

  assign two_r = {r_eff, 1'b0};

  // Item decode in idle: which columns this word finishes.
  logic          accept, drain, ignore, c_last, c_ge_r, has_work;
  logic [XW-1:0] lo;

  assign accept   = in_chan.valid && in_chan.ready;
  assign drain    = row_r >= h_eff;
  assign ignore   = !drain && in_chan.opcode;
  assign c_last   = EW'(col_r) == (w_eff - EW'(1));
  assign c_ge_r   = col_r >= XW'(r_eff);
  assign has_work = c_last || c_ge_r;
  assign lo       = c_ge_r ? (col_r - XW'(r_eff)) : '0;

  // Position advance at the end of an item.
  logic [RW:0]    row_p1;
  logic [3:0]     slot_p1;
  logic [XW-1:0]  col_adv;
  logic [RW-1:0]  row_adv;
  logic [SLW-1:0] slot_adv;

  always_comb begin
    row_p1   = {1'b0, row_r} + (RW+1)'(1);
    slot_p1  = 4'(slot_r) + 4'd1;
    col_adv  = col_r + XW'(1);
    row_adv  = row_r;
    slot_adv = slot_r;
    if (c_last) begin
      col_adv = '0;
      if (row_p1 >= ({1'b0, h_eff} + (RW+1)'(r_eff))) begin
        row_adv  = '0;
        slot_adv = '0;
      end else begin
        row_adv  = row_p1[RW-1:0];
        slot_adv = (slot_p1 >= two_r) ? '0 : SLW'(slot_p1);
      end
    end
  end

  // Row window: a chain of pixel cells, newest pixel in cell 0.
  logic                      shift_en;
  logic [sgs_pkg::PIX_W-1:0] win [WIN_LEN];

  assign shift_en = accept && !drain && !in_chan.opcode;

  for (genvar i = 0; i < WIN_LEN; i++) begin : g_win
    if (i == 0) begin : g_head
      sgs_cell u_cell (.clk(clk), .rst_n(rst_n), .shift_en(shift_en),
                       .pix_in(in_chan.pixel), .pix_out(win[i]));
    end else begin : g_body
      sgs_cell u_cell (.clk(clk), .rst_n(rst_n), .shift_en(shift_en),
                       .pix_in(win[i-1]), .pix_out(win[i]));
    end
  end

  // Tap weight for step t: offset |t - R|.
  logic [3:0]                  absd4;
  logic [sgs_pkg::COEF_W-1:0]  wt;

  assign absd4 = (t_r < 4'(r_eff)) ? (4'(r_eff) - t_r) : (t_r - 4'(r_eff));
  assign wt    = sgs_pkg::tap_weight(coef_in_r, coef_out_r, absd4[2:0]);

  // Horizontal tap: pixel column x + d, held at window index c - (x + d).
  logic signed [4:0]    dsg;
  logic signed [SW-1:0] pos, kidx;
  logic                 h_ok;
  logic [23:0]          h_prod;

  assign dsg    = $signed({1'b0, t_r}) - $signed({2'b00, r_eff});
  assign pos    = $signed({2'b00, x_r}) + SW'(dsg);
  assign kidx   = $signed({2'b00, col_r}) - pos;
  assign h_ok   = (pos >= 0) && (kidx >= 0) && (kidx < SW'(WIN_LEN));
  assign h_prod = 24'(win[kidx[KW-1:0]]) * 24'(wt);

  // Vertical tap: row r - 2R + t, the current row comes from h_r.
  logic signed [JW-1:0]       jrow;
  logic                       v_ok, v_cur;
  logic [sgs_pkg::HVAL_W-1:0] v_val;
  logic [31:0]                v_prod;

  assign jrow   = $signed({2'b00, row_r}) - $signed(JW'(two_r)) + $signed(JW'(t_r));
  assign v_ok   = (jrow >= 0) && (jrow < $signed({2'b00, h_eff}));
  assign v_cur  = t_r == two_r;
  assign v_val  = v_cur ? h_r : mem_q_r;
  assign v_prod = 32'(v_val) * 32'(wt);

  // Line store: read in S_VRD, write in S_WR.
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;

  assign rd_addr = AW'(vslot_r) * AW'(MAX_WIDTH) + AW'(x_r);
  assign wr_addr = AW'(slot_r) * AW'(MAX_WIDTH) + AW'(x_r);
  assign wr_en   = (state_r == S_WR) && !drain_r && (r_eff != '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= h_r;
    end
    mem_q_r <= store_mem[rd_addr];
  end

  // Shared divider.
  sgs_pkg::div_req_t div_req;
  sgs_pkg::div_rsp_t div_rsp;

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = vnum_r;
    div_req.den   = vsum_r;
    if (state_r == S_HSTART) begin
      div_req.start = sum_r != '0;
      div_req.num   = sgs_pkg::DIV_NUM_W'({dot_r, 8'b0}) +
                      sgs_pkg::DIV_NUM_W'(sum_r >> 1);
      div_req.den   = sum_r;
    end else if (state_r == S_VSTART) begin
      div_req.start = vsum_r != '0;
    end
  end

  sgs_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // Result flags.
  logic [RW-1:0] orow;
  logic          frame_end;
  logic          out_free;

  assign orow      = row_r - RW'(r_eff);
  assign frame_end = (orow == (h_eff - RW'(1))) && (EW'(x_r) == (w_eff - EW'(1)));
  assign out_free  = !out_valid_r || out_chan.ready;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !ignore && has_work) begin
          state_nxt = S_XBEG;
        end
      end
      S_XBEG:   state_nxt = drain_r ? S_VBEG : S_HACC;
      S_HACC:   state_nxt = (t_r == two_r) ? S_HSTART : S_HACC;
      S_HSTART: state_nxt = (sum_r == '0) ? S_VBEG : S_HDIV;
      S_HDIV:   state_nxt = div_rsp.done ? S_VBEG : S_HDIV;
      S_VBEG:   state_nxt = (row_r >= RW'(r_eff)) ? S_VRD : S_WR;
      S_VRD:    state_nxt = S_VACC;
      S_VACC:   state_nxt = v_cur ? S_VNUM : S_VRD;
      S_VNUM:   state_nxt = S_VSTART;
      S_VSTART: state_nxt = (vsum_r == '0) ? S_OUT : S_VDIV;
      S_VDIV:   state_nxt = div_rsp.done ? S_OUT : S_VDIV;
      S_OUT:    state_nxt = out_free ? S_WR : S_OUT;
      S_WR:     state_nxt = (x_r == hi_r) ? S_IDLE : S_XBEG;
      default:  state_nxt = S_IDLE;
    endcase
  end

  assign in_chan.ready = state_r == S_IDLE;

  // Control registers: state, configuration, raster position, output word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      img_w_r     <= sgs_pkg::DIM_W'(1024);
      img_h_r     <= sgs_pkg::DIM_W'(1024);
      rad_r       <= sgs_pkg::RAD_W'(7);
      coef_in_r   <= '0;
      coef_out_r  <= '0;
      col_r       <= '0;
      row_r       <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Advance the raster position once the item is done.
      if ((state_r == S_IDLE && accept && !ignore && !has_work) ||
          (state_r == S_WR && x_r == hi_r)) begin
        col_r  <= col_adv;
        row_r  <= row_adv;
        slot_r <= slot_adv;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          sgs_pkg::REG_IMAGE_WIDTH: begin
            img_w_r <= cfg_wdata[sgs_pkg::DIM_W-1:0];
            col_r   <= '0;
            row_r   <= '0;
            slot_r  <= '0;
          end
          sgs_pkg::REG_IMAGE_HEIGHT: begin
            img_h_r <= cfg_wdata[sgs_pkg::DIM_W-1:0];
            col_r   <= '0;
            row_r   <= '0;
            slot_r  <= '0;
          end
          sgs_pkg::REG_KERNEL_RAD: begin
            rad_r  <= cfg_wdata[sgs_pkg::RAD_W-1:0];
            col_r  <= '0;
            row_r  <= '0;
            slot_r <= '0;
          end
          sgs_pkg::REG_COEF_INNER: coef_in_r  <= cfg_wdata;
          sgs_pkg::REG_COEF_OUTER: coef_out_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        x_r     <= lo;
        hi_r    <= c_last ? col_r : lo;
        drain_r <= drain;
      end
      S_XBEG: begin
        t_r   <= '0;
        dot_r <= '0;
        sum_r <= '0;
        h_r   <= '0;
      end
      S_HACC: begin
        if (h_ok) begin
          dot_r <= dot_r + sgs_pkg::HDOT_W'(h_prod);
          sum_r <= sum_r + sgs_pkg::WSUM_W'(wt);
        end
        t_r <= t_r + 4'd1;
      end
      S_HDIV: begin
        if (div_rsp.done) begin
          h_r <= div_rsp.quot;
        end
      end
      S_VBEG: begin
        t_r     <= '0;
        vdot_r  <= '0;
        vsum_r  <= '0;
        vslot_r <= slot_r;
      end
      S_VACC: begin
        if (v_ok) begin
          vdot_r <= vdot_r + sgs_pkg::VDOT_W'(v_prod);
          vsum_r <= vsum_r + sgs_pkg::WSUM_W'(wt);
        end
        t_r     <= t_r + 4'd1;
        vslot_r <= ((4'(vslot_r) + 4'd1) >= two_r) ? '0 : SLW'(4'(vslot_r) + 4'd1);
      end
      S_VNUM: begin
        // vd*90 + vs*128, pre-divided by 256; 90 = 64 + 16 + 8 + 2.
        vnum_r <= sgs_pkg::DIV_NUM_W'(((44'(vdot_r) << 6) + (44'(vdot_r) << 4) +
                                       (44'(vdot_r) << 3) + (44'(vdot_r) << 1) +
                                       (44'(vsum_r) << 7)) >> 8);
      end
      S_VSTART: begin
        vres_r <= '0;
      end
      S_VDIV: begin
        if (div_rsp.done) begin
          vres_r <= div_rsp.quot[sgs_pkg::SMOOTH_W-1:0];
        end
      end
      S_OUT: begin
        // Load the output word only once the previous one has left.
        if (out_free) begin
          out_smooth_r <= vres_r;
          out_fe_r     <= frame_end;
          out_last_r   <= x_r == hi_r;
        end
      end
      S_WR: begin
        x_r <= x_r + XW'(1);
      end
      default: ;
    endcase
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.smoothed  = out_smooth_r;
  assign out_chan.frame_end = out_fe_r;
  assign out_chan.run_last  = out_last_r;

endmodule

// ----- rtl/sgs_checker.sv -----
module sgs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [sgs_pkg::SMOOTH_W-1:0] smoothed,
  input logic                         frame_end,
  input logic                         run_last
);

  // Hold a stalled word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(smoothed))
    else $error("stalled output word dropped or changed");

  // Scaled result never exceeds 255 times 90.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> smoothed <= sgs_pkg::SMOOTH_W'(22950))
    else $error("smoothed value out of range");

  // The frame's last pixel is the last word of its item.
  a_fe_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_end |-> run_last)
    else $error("frame_end without run_last");

  // Flags hold with the word while stalled.
  a_flag_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(frame_end) && $stable(run_last))
    else $error("stalled output flags changed");

endmodule

bind separable_gaussian_smoother_unit sgs_checker u_sgs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .smoothed  (out_chan.smoothed),
  .frame_end (out_chan.frame_end),
  .run_last  (out_chan.run_last)
);

// ----- test/tb_top.sv -----
// One blurred output word as the block should present it.
typedef struct {
  bit [sgs_pkg::SMOOTH_W-1:0] smoothed;
  bit                         frame_end;
  bit                         run_last;
} blur_word_t;

class smoother_scoreboard;
  localparam int WIN_DEPTH = 15;
  localparam int LINE_CAP  = 2 * 7 * 1024;

  bit [sgs_pkg::DIM_W-1:0]  width_reg;
  bit [sgs_pkg::DIM_W-1:0]  height_reg;
  bit [sgs_pkg::RAD_W-1:0]  radius_reg;
  bit [sgs_pkg::CFG_W-1:0]  inner_taps;
  bit [sgs_pkg::CFG_W-1:0]  outer_taps;
  bit [sgs_pkg::PIX_W-1:0]  recent_pixels[WIN_DEPTH];
  bit [sgs_pkg::HVAL_W-1:0] row_blur_store[LINE_CAP];
  int col_pos;
  int row_pos;
  blur_word_t expected_words[$];
  int errors;

  function void clear_state();
    width_reg  = sgs_pkg::DIM_W'(1024);
    height_reg = sgs_pkg::DIM_W'(1024);
    radius_reg = sgs_pkg::RAD_W'(7);
    inner_taps = '0;
    outer_taps = '0;
    foreach (recent_pixels[i]) recent_pixels[i] = '0;
    foreach (row_blur_store[i]) row_blur_store[i] = '0;
    col_pos = 0;
    row_pos = 0;
    expected_words.delete();
    errors = 0;
  endfunction

  function void write_reg(sgs_pkg::sgs_reg_t idx, bit [sgs_pkg::CFG_W-1:0] data);
    case (idx)
      sgs_pkg::REG_IMAGE_WIDTH: begin
        width_reg = data[sgs_pkg::DIM_W-1:0];
      end
      sgs_pkg::REG_IMAGE_HEIGHT: begin
        height_reg = data[sgs_pkg::DIM_W-1:0];
      end
      sgs_pkg::REG_KERNEL_RAD: begin
        radius_reg = data[sgs_pkg::RAD_W-1:0];
      end
      sgs_pkg::REG_COEF_INNER: begin
        inner_taps = data;
        return;
      end
      sgs_pkg::REG_COEF_OUTER: begin
        outer_taps = data;
        return;
      end
      default: return;
    endcase
    // geometry writes restart the frame
    col_pos = 0;
    row_pos = 0;
  endfunction

  function longint unsigned weight_at(int k);
    if (k < 4) return inner_taps[16*k +: 16];
    return outer_taps[16*(k-4) +: 16];
  endfunction

  function int cols();
    if (width_reg == 0) return 1;
    if (width_reg > 1024) return 1024;
    return width_reg;
  endfunction

  function int rows();
    if (height_reg == 0) return 1;
    if (height_reg > sgs_pkg::HEIGHT_LIM) return sgs_pkg::HEIGHT_LIM;
    return height_reg;
  endfunction

  // Horizontal 8.8 value for column x while the newest pixel sits at column c.
  function longint unsigned row_blur(int x, int c, int rad);
    longint unsigned acc, wsum, w;
    int pos, k;
    acc = 0;
    wsum = 0;
    for (int d = -rad; d <= rad; d++) begin
      pos = x + d;
      k = c - pos;
      if (pos < 0 || pos > c || k < 0 || k >= WIN_DEPTH) continue;
      w = weight_at(d < 0 ? -d : d);
      acc += recent_pixels[k] * w;
      wsum += w;
    end
    if (wsum == 0) return 0;
    return (acc * 256 + wsum / 2) / wsum;
  endfunction

  // Vertical pass: blurred value times 90 for output row orow, column x.
  function longint unsigned column_blur(int orow, int x, int r, int hgt, int rad,
                                        longint unsigned hcur);
    longint unsigned acc, wsum, w, v;
    int j;
    acc = 0;
    wsum = 0;
    for (int d = -rad; d <= rad; d++) begin
      j = orow + d;
      if (j < 0 || j >= hgt || j > r) continue;
      if (j == r) v = hcur;
      else v = row_blur_store[(j % (2 * rad)) * 1024 + x];
      w = weight_at(d < 0 ? -d : d);
      acc += v * w;
      wsum += w;
    end
    if (wsum == 0) return 0;
    return (acc * 90 + wsum * 128) / (wsum * 256);
  endfunction

  // Advance the predicted raster position by one accepted word and queue its results.
  function void note_input(bit op, bit [sgs_pkg::PIX_W-1:0] px);
    int wid, hgt, rad, c, r, lo, hi;
    bit draining;
    longint unsigned h;
    blur_word_t word;
    blur_word_t fresh[$];
    wid = cols();
    hgt = rows();
    rad = radius_reg;
    if (col_pos >= wid || row_pos >= hgt + rad) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    draining = (r >= hgt);
    if (!draining && op) return;   // flush inside the picture: drop it
    if (!draining) begin
      for (int i = WIN_DEPTH - 1; i > 0; i--) recent_pixels[i] = recent_pixels[i-1];
      recent_pixels[0] = px;
    end
    if (c == wid - 1) begin
      lo = (c >= rad) ? c - rad : 0;
      hi = c;
    end else if (c >= rad) begin
      lo = c - rad;
      hi = c - rad;
    end else begin
      lo = 0;
      hi = -1;
    end
    for (int x = lo; x <= hi; x++) begin
      h = draining ? 0 : row_blur(x, c, rad);
      if (r >= rad) begin
        word.smoothed  = sgs_pkg::SMOOTH_W'(column_blur(r - rad, x, r, hgt, rad, h));
        word.frame_end = (r - rad == hgt - 1) && (x == wid - 1);
        word.run_last  = 1'b0;
        fresh.push_back(word);
      end
      if (!draining && rad > 0) begin
        row_blur_store[(r % (2 * rad)) * 1024 + x] = sgs_pkg::HVAL_W'(h);
      end
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].run_last = 1'b1;
    foreach (fresh[i]) expected_words.push_back(fresh[i]);
    c++;
    if (c >= wid) begin
      c = 0;
      r++;
      if (r >= hgt + rad) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  function void check(bit [sgs_pkg::SMOOTH_W-1:0] smoothed, bit frame_end, bit run_last);
    blur_word_t exp_w;
    if (expected_words.size() == 0) begin
      $error("unexpected output word: smoothed=%0d", smoothed);
      errors++;
      return;
    end
    exp_w = expected_words.pop_front();
    if (smoothed !== exp_w.smoothed) begin
      $error("smoothed: expected %0d, got %0d", exp_w.smoothed, smoothed);
      errors++;
    end
    if (frame_end !== exp_w.frame_end) begin
      $error("frame_end: expected %0d, got %0d", exp_w.frame_end, frame_end);
      errors++;
    end
    if (run_last !== exp_w.run_last) begin
      $error("run_last: expected %0d, got %0d", exp_w.run_last, run_last);
      errors++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Worst case: 8 results per word, stretched by stalls.
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_WAIT  = 200;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [sgs_pkg::CFG_W-1:0] cfg_wdata;

  sgs_in_if  in_if ();
  sgs_out_if out_if ();

  separable_gaussian_smoother_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if.sink),
    .out_chan  (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  smoother_scoreboard blur_sb;
  int send_idle_pct;
  int recv_idle_pct;
  int words_sent;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: roll ready at every falling edge according to the current idle rate.
  always @(negedge clk) begin
    if (rst_n) out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: note accepted input words before checking accepted outputs.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) blur_sb.write_reg(sgs_pkg::sgs_reg_t'(cfg_index), cfg_wdata);
      if (in_if.valid && in_if.ready) blur_sb.note_input(in_if.opcode, in_if.pixel);
      if (out_if.valid && out_if.ready) begin
        blur_sb.check(out_if.smoothed, out_if.frame_end, out_if.run_last);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Present one word; return at the edge that takes it. Valid stays high between words
  // unless the sender idles, so it is never lowered and raised in the same step.
  task automatic send_word(bit op, bit [sgs_pkg::PIX_W-1:0] px);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.pixel  <= px;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    words_sent++;
  endtask

  // Hold until every expected word has come out and the block has settled.
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (blur_sb.expected_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic program_regs(bit [sgs_pkg::CFG_W-1:0] wid, bit [sgs_pkg::CFG_W-1:0] hgt,
                              bit [sgs_pkg::CFG_W-1:0] rad,
                              bit [sgs_pkg::CFG_W-1:0] inner,
                              bit [sgs_pkg::CFG_W-1:0] outer);
    bit [sgs_pkg::CFG_W-1:0] vals[5];
    vals = '{wid, hgt, rad, inner, outer};
    wait_idle();
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= i[2:0];
      cfg_wdata <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic bit [sgs_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic bit [15:0] rand_weight();
    case ($urandom_range(6))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic bit [sgs_pkg::CFG_W-1:0] rand_taps();
    return {rand_weight(), rand_weight(), rand_weight(), rand_weight()};
  endfunction

  // Drive one frame: picture words with stray flushes, then the drain rows with stray
  // pixels. A truncated frame stops after a random prefix.
  task automatic run_frame(int wid, int hgt, int rad, int noise_pct, bit truncate);
    int stop_at;
    int sent;
    stop_at = truncate ? $urandom_range(wid * (hgt + rad)) : wid * (hgt + rad);
    sent = 0;
    for (int slot = 0; slot < wid * hgt && sent < stop_at; slot++) begin
      if ($urandom_range(99) < noise_pct) send_word(1'b1, 8'($urandom_range(255)));
      send_word(1'b0, rand_pixel());
      sent++;
    end
    for (int slot = 0; slot < wid * rad && sent < stop_at; slot++) begin
      if ($urandom_range(99) < noise_pct) send_word(1'b0, 8'($urandom_range(255)));
      else send_word(1'b1, 8'($urandom_range(255)));
      sent++;
    end
  endtask

  initial begin
    int wid, hgt, rad;
    blur_sb = new();
    blur_sb.clear_state();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.opcode = 1'b0;
    in_if.pixel = '0;
    out_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    words_sent = 0;
    cycle_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: single pixel frame, no kernel, unit weight; black then white.
    program_regs(1, 1, 0, 64'h0000_0000_0000_FFFF, 64'h0);
    send_word(1'b0, 8'd0);
    send_word(1'b0, 8'd255);
    // Zero weights everywhere, flush in the picture, pixel in the drain rows, wrap.
    program_regs(3, 2, 1, 64'h0, 64'h0);
    send_word(1'b0, 8'd255);
    send_word(1'b1, 8'd17);
    for (int i = 0; i < 5; i++) send_word(1'b0, 8'(128 + i));
    send_word(1'b0, 8'd99);
    send_word(1'b1, 8'd0);
    send_word(1'b1, 8'd0);
    send_word(1'b0, 8'd1);
    // Zero dimensions act as one; widest kernel, all weights full scale.
    program_regs(0, 0, 7, {sgs_pkg::CFG_W{1'b1}}, {sgs_pkg::CFG_W{1'b1}});
    for (int i = 0; i < 8; i++) send_word(i[0], 8'd255);
    // Oversized geometry clamps to the maximum; only the start of the top row is touched.
    program_regs(2047, 2047, 7, 64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321);
    for (int i = 0; i < 6; i++) send_word(1'b0, rand_pixel());
    // Largest legal width, then a one row tall image; the last column reaches 8 results.
    program_regs(1024, 1024, 7, rand_taps(), rand_taps());
    for (int i = 0; i < 4; i++) send_word(1'b0, rand_pixel());
    program_regs(9, 1, 7, rand_taps(), rand_taps());
    run_frame(9, 1, 7, 0, 1'b0);

    // Random frames in three idle regimes.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 31 : 0;
      words_sent = 0;
      while (words_sent < 10) begin
        wid = $urandom_range(1, 6);
        hgt = $urandom_range(1, 3);
        rad = $urandom_range(0, 7);
        program_regs(wid, hgt, rad, rand_taps(), rand_taps());
        run_frame(wid, hgt, rad, 8, $urandom_range(4) == 0);
        // sometimes roll straight into the next frame
        if ($urandom_range(3) == 0) run_frame(wid, hgt, rad, 5, 1'b1);
      end
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (blur_sb.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (blur_sb.errors == 0 && blur_sb.expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/sgs_pkg.sv
rtl/sgs_if.sv
rtl/sgs_cell.sv
rtl/sgs_div.sv
rtl/separable_gaussian_smoother_unit.sv
rtl/sgs_checker.sv
test/tb_top.sv
